// File: hw/rtl/ost_pkg.sv
`default_nettype none

package ost_pkg;

	// Field widths
	localparam int ACTION_W = 2;
	localparam int INDEX_W  = 5;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 6;

	// The 5-bit index caps the number of slots a tick can reach
	localparam int INDEX_LIMIT = 1 << INDEX_W;

	// Default bank size
	localparam int TIMER_SLOTS_DEF = 32;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

	// One result transaction
	typedef struct packed {
		logic               fired;
		logic [INDEX_W-1:0] fired_index;
		logic [TIME_W-1:0]  timestamp;
		logic               last;
	} res_t;

	// Scan sequencer states
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/ost_ram.sv
`default_nettype none

module ost_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; hold data while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ost_out.sv
`default_nettype none

module ost_out (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire ost_pkg::res_t res_in,
	output logic               free,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               fired,
	output logic [4:0]         fired_index,
	output logic [31:0]        timestamp,
	output logic               last
);

	import ost_pkg::*;

	logic valid_q;
	res_t res_q;

	// Register may take a new result when empty or being drained
	assign free = !valid_q || out_ready;

	// Hold a result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid   = valid_q;
	assign fired       = res_q.fired;
	assign fired_index = res_q.fired_index;
	assign timestamp   = res_q.timestamp;
	assign last        = res_q.last;

endmodule

`default_nettype wire

// File: hw/rtl/one_shot_timer_bank.sv
// Bank of one-shot countdown timers.
// Input channel (in_valid/in_ready): action, timer_index, amount. A start loads
// a slot with a duration and arms it, a stop clears and disarms it, a tick adds
// amount to the wrapping timestamp and scans slots 0 .. slots_in_use-1, capped at the bank size.
// Output channel (out_valid/out_ready): one transaction per expired slot in
// index order, or one non-fired transaction; last marks the final one.
// Configuration: cfg_we writes cfg_wdata into slots_in_use; the user must
// write it only while idle, the block itself does not enforce it. Start, stop
// and ticks that scan no slot give a result visible the following cycle.
// With one read and one write port on the slot memory, the scan visits one slot
// a cycle unless an expiry stalls on the output, writing back the slot read the
// cycle before. Each fired result is held one expiry back so last can be set.
// Reset clears the timestamp, slots_in_use and the per-slot valid flags, so
// every slot reads as disarmed; the slot memory itself needs no clearing.
// When the receiver stalls, the single output register holds its result and
// the scan pauses on the next expiring slot; a start, stop or short tick is
// taken as soon as the output register is free or being drained.
`default_nettype none

module one_shot_timer_bank #(
	parameter int TIMER_SLOTS = ost_pkg::TIMER_SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ost_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [ost_pkg::ACTION_W-1:0] action,
	input  wire logic [ost_pkg::INDEX_W-1:0]  timer_index,
	input  wire logic [ost_pkg::TIME_W-1:0]   amount,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              fired,
	output logic [ost_pkg::INDEX_W-1:0]       fired_index,
	output logic [ost_pkg::TIME_W-1:0]        timestamp,
	output logic                              last
);

	import ost_pkg::*;

	localparam int AW       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int SCAN_MAX = (TIMER_SLOTS < INDEX_LIMIT) ? TIMER_SLOTS : INDEX_LIMIT;
	localparam int RW       = TIME_W + 1;

	state_t              state_q;
	logic [CFG_W-1:0]    slots_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic [TIME_W-1:0]   amount_q;
	logic [CFG_W-1:0]    scan_n_q;
	logic [CFG_W-1:0]    iss_q;
	logic [INDEX_W-1:0]  ev_idx_s1;
	logic                vld_s1;
	logic [TIMER_SLOTS-1:0] vld_q;
	logic                pend_vld_q;
	logic [INDEX_W-1:0]  pend_idx_q;

	logic                in_acc;
	logic [CFG_W-1:0]    scan_n;
	logic                in_range;
	logic [TIME_W-1:0]   ts_next;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [RW-1:0]       ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [RW-1:0]       ram_rdata;

	logic                ev_armed;
	logic [TIME_W-1:0]   ev_cd;
	logic                ev_fire;
	logic                stall;
	logic                advance;
	logic                more;

	logic                out_free;
	logic                out_load;
	res_t                out_res;

	// Handshake
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;

	// Slots a tick scans: bounded by the bank and by the index width
	assign scan_n   = (slots_q > CFG_W'(SCAN_MAX)) ? CFG_W'(SCAN_MAX) : slots_q;
	assign in_range = (32'(timer_index) < TIMER_SLOTS);
	assign ts_next  = (action == ACT_TICK) ? (elapsed_q + amount) : elapsed_q;

	// Evaluate the slot whose read data is present
	assign ev_armed = ram_rdata[RW-1] && vld_s1;
	assign ev_cd    = ram_rdata[TIME_W-1:0];
	assign ev_fire  = ev_armed && (ev_cd <= amount_q);
	assign stall    = ev_fire && pend_vld_q && !out_free;
	assign advance  = (state_q == S_SCAN) && !stall;
	assign more     = (iss_q < scan_n_q);

	// Memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(timer_index);
		ram_wdata = {1'b0, {TIME_W{1'b0}}};
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if ((action == ACT_START || action == ACT_STOP) && in_range) begin
						ram_we    = 1'b1;
						ram_wdata = (action == ACT_START) ? {1'b1, amount}
						                                  : {1'b0, {TIME_W{1'b0}}};
					end
					if (action == ACT_TICK && scan_n != '0) begin
						ram_re = 1'b1;
					end
				end
			end
			S_SCAN: begin
				ram_waddr = AW'(ev_idx_s1);
				if (advance) begin
					ram_we    = ev_armed;
					ram_wdata = ev_fire ? {1'b0, {TIME_W{1'b0}}}
					                    : {1'b1, ev_cd - amount_q};
					ram_re    = more;
					ram_raddr = AW'(iss_q[INDEX_W-1:0]);
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	ost_ram #(
		.WIDTH (RW),
		.DEPTH (TIMER_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register load
	always_comb begin
		out_load = 1'b0;
		out_res  = '{fired: 1'b0, fired_index: '0, timestamp: elapsed_q, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && !(action == ACT_TICK && scan_n != '0)) begin
					out_load          = 1'b1;
					out_res.timestamp = ts_next;
				end
			end
			S_SCAN: begin
				if (ev_fire && pend_vld_q && out_free) begin
					out_load            = 1'b1;
					out_res.fired       = 1'b1;
					out_res.fired_index = pend_idx_q;
					out_res.last        = 1'b0;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load            = 1'b1;
					out_res.fired       = pend_vld_q;
					out_res.fired_index = pend_vld_q ? pend_idx_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	ost_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (out_load),
		.res_in      (out_res),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fired       (fired),
		.fired_index (fired_index),
		.timestamp   (timestamp),
		.last        (last)
	);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			slots_q    <= '0;
			elapsed_q  <= '0;
			vld_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				slots_q <= cfg_wdata;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && action == ACT_TICK) begin
						elapsed_q <= ts_next;
						if (scan_n != '0) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (advance) begin
						if (ev_fire) begin
							pend_vld_q <= 1'b1;
						end
						if (!more) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Scan datapath registers
	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_TICK) begin
			amount_q <= amount;
			scan_n_q <= scan_n;
			iss_q    <= CFG_W'(1);
		end else if (advance && more) begin
			iss_q <= iss_q + CFG_W'(1);
		end
		if (ram_re) begin
			ev_idx_s1 <= (state_q == S_SCAN) ? iss_q[INDEX_W-1:0] : '0;
			vld_s1    <= vld_q[ram_raddr];
		end
		if (advance && ev_fire) begin
			pend_idx_q <= ev_idx_s1;
		end
	end

	// Input is taken only between scans
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("input accepted during a scan");

	// A held expiry exists only while a tick is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_vld_q)
		else $error("pending expiry left over after a tick");

	// The scan never issues past the slots in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (iss_q <= scan_n_q) && (scan_n_q != '0))
		else $error("scan counter out of range");

	// The write-back never targets the slot being read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("slot memory read and write collide");

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;
	import ost_pkg::*;

	localparam int BANK = TIMER_SLOTS_DEF;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACTION_W-1:0] action = ACT_START;
	logic [INDEX_W-1:0]  timer_index = '0;
	logic [TIME_W-1:0]   amount = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                fired;
	logic [INDEX_W-1:0]  fired_index;
	logic [TIME_W-1:0]   timestamp;
	logic                last;

	// Timer bank copy kept by the testbench
	logic [TIME_W-1:0] slot_count[BANK];
	logic              slot_armed[BANK];
	logic [TIME_W-1:0] clock_total;
	logic [CFG_W-1:0]  slots_cfg;

	res_t pending_results[$];
	int   errors = 0;
	bit   idle_on = 1'b1;
	int   hold_req = 0;
	int   quiet = 0;

	one_shot_timer_bank #(
		.TIMER_SLOTS(BANK)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.timer_index(timer_index),
		.amount(amount),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fired(fired),
		.fired_index(fired_index),
		.timestamp(timestamp),
		.last(last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h, want %0h (t=%0t)", what, got, want, $time);
		errors++;
	endtask

	// Work out the results of one accepted transaction and queue them
	function automatic void predict_timers(input logic [ACTION_W-1:0] act,
			input logic [INDEX_W-1:0] idx, input logic [TIME_W-1:0] amt);
		int   scan;
		int   hits[$];
		res_t r;
		if (act == ACT_START || act == ACT_STOP) begin
			if (int'(idx) < BANK) begin
				slot_count[idx] = (act == ACT_START) ? amt : '0;
				slot_armed[idx] = (act == ACT_START);
			end
		end else if (act == ACT_TICK) begin
			scan = int'(slots_cfg);
			if (scan > BANK)
				scan = BANK;
			if (scan > INDEX_LIMIT)
				scan = INDEX_LIMIT;
			clock_total = clock_total + amt;
			for (int i = 0; i < scan; i++) begin
				if (slot_armed[i]) begin
					if (slot_count[i] <= amt) begin
						slot_armed[i] = 1'b0;
						slot_count[i] = '0;
						hits.push_back(i);
					end else begin
						slot_count[i] = slot_count[i] - amt;
					end
				end
			end
		end
		if (hits.size() == 0) begin
			r = '{fired: 1'b0, fired_index: '0, timestamp: clock_total, last: 1'b1};
			pending_results.push_back(r);
		end else begin
			foreach (hits[k]) begin
				r.fired = 1'b1;
				r.fired_index = hits[k][INDEX_W-1:0];
				r.timestamp = clock_total;
				r.last = (k == hits.size() - 1);
				pending_results.push_back(r);
			end
		end
	endfunction

	// Offer one transaction, leaving valid high after acceptance
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
			input logic [TIME_W-1:0] amt);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		timer_index <= idx;
		amount <= amt;
		do
			@(posedge clk);
		while (!in_ready);
		predict_timers(act, idx, amt);
	endtask

	// Drop valid and hold until every queued result has been taken
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_slots(input logic [CFG_W-1:0] value);
		wait_drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		slots_cfg = value;
	endtask

	function automatic logic [TIME_W-1:0] pick_amount();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return $urandom_range(0, 40);
	endfunction

	// Mostly address slots that are scanned so that timers really expire
	task automatic send_random_item();
		int sel;
		int reach;
		logic [INDEX_W-1:0] idx;
		reach = (int'(slots_cfg) > BANK) ? BANK : int'(slots_cfg);
		if (reach > 0 && $urandom_range(0, 3) != 0)
			idx = INDEX_W'($urandom_range(0, reach - 1));
		else
			idx = INDEX_W'($urandom_range(0, 31));
		sel = $urandom_range(0, 99);
		if (sel < 45)
			send_item(ACT_START, idx, pick_amount());
		else if (sel < 55)
			send_item(ACT_STOP, idx, $urandom);
		else if (sel < 95)
			send_item(ACT_TICK, INDEX_W'($urandom_range(0, 31)), pick_amount());
		else
			send_item(ACT_RESERVED, idx, $urandom);
	endtask

	task automatic test_directed();
		// Nothing scanned straight after reset
		send_item(ACT_TICK, 5'd0, 32'd7);
		send_item(ACT_START, 5'd0, 32'd0);
		send_item(ACT_TICK, 5'd0, 32'd0);
		// Oversized slot count clamps to the bank; zero duration fires on a zero tick
		write_slots(6'd63);
		send_item(ACT_TICK, 5'd31, 32'd0);
		send_item(ACT_START, 5'd5, 32'd10);
		send_item(ACT_START, 5'd31, 32'hFFFF_FFFF);
		send_item(ACT_START, 5'd7, 32'd5);
		send_item(ACT_STOP, 5'd7, 32'hFFFF_FFFF);
		send_item(ACT_STOP, 5'd12, 32'd0);
		send_item(ACT_TICK, 5'd0, 32'd10);
		// Full-range tick expires the top slot and wraps the timestamp
		send_item(ACT_TICK, 5'd0, 32'hFFFF_FFFF);
		send_item(ACT_RESERVED, 5'd31, 32'hFFFF_FFFF);
		// Slot outside the scanned range keeps its state until it is in use
		send_item(ACT_START, 5'd3, 32'd1);
		send_item(ACT_START, 5'd20, 32'd1);
		write_slots(6'd4);
		send_item(ACT_TICK, 5'd0, 32'd5);
		write_slots(6'd21);
		send_item(ACT_TICK, 5'd0, 32'd0);
		send_item(ACT_TICK, 5'd0, 32'd1);
		// Several expiries on one tick
		send_item(ACT_START, 5'd0, 32'd2);
		send_item(ACT_START, 5'd1, 32'd2);
		send_item(ACT_START, 5'd2, 32'd3);
		send_item(ACT_TICK, 5'd0, 32'd2);
		send_item(ACT_TICK, 5'd0, 32'd1);
	endtask

	task automatic test_backpressure();
		write_slots(6'd32);
		for (int i = 0; i < BANK; i++)
			send_item(ACT_START, i[INDEX_W-1:0], $urandom_range(1, 3));
		// Hold the receiver off while ticks and starts keep coming
		hold_req <= 100;
		for (int i = 0; i < 6; i++)
			send_item(ACT_TICK, 5'd0, 32'd3);
		for (int i = 0; i < 4; i++)
			send_item(ACT_START, INDEX_W'($urandom_range(0, 31)), $urandom_range(0, 5));
		wait_drain();
		send_item(ACT_TICK, 5'd0, 32'd6);
	endtask

	task automatic test_random_phases();
		logic [CFG_W-1:0] settings[8];
		settings = '{6'd1, 6'd32, 6'd5, 6'd63, 6'd0, 6'd17, 6'd33, 6'd0};
		settings[7] = CFG_W'($urandom_range(0, 63));
		foreach (settings[p]) begin
			write_slots(settings[p]);
			for (int i = 0; i < 30; i++)
				send_random_item();
		end
	endtask

	task automatic test_full_rate();
		write_slots(6'd32);
		idle_on = 1'b0;
		for (int i = 0; i < 40; i++)
			send_random_item();
	endtask

	// Receiver: random stalls plus the long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req <= 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'({fired_index, fired}), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (fired !== want.fired)
					report_mismatch("fired", 32'(fired), 32'(want.fired));
				if (fired_index !== want.fired_index)
					report_mismatch("fired_index", 32'(fired_index),
						32'(want.fired_index));
				if (timestamp !== want.timestamp)
					report_mismatch("timestamp", timestamp, want.timestamp);
				if (last !== want.last)
					report_mismatch("last", 32'(last), 32'(want.last));
			end
		end
	end

	// Stop the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < BANK; i++) begin
			slot_count[i] = '0;
			slot_armed[i] = 1'b0;
		end
		clock_total = '0;
		slots_cfg = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_phases();
		test_full_rate();
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/ost_pkg.sv
hw/rtl/ost_ram.sv
hw/rtl/ost_out.sv
hw/rtl/one_shot_timer_bank.sv
test/tb.sv
